FILE: hdl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants of the timed event queue
// Sizes, mode and status codes, channel beats and the front/back command.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned TimeBits = 32;
  localparam int unsigned TagBits  = 16;
  localparam int unsigned IdxBits  = $clog2(Capacity);
  localparam int unsigned CntBits  = $clog2(Capacity + 1);
  localparam int unsigned CmdDepth = 2;

  typedef enum logic [1:0] {
    MODE_ADD_AFTER = 2'd0,
    MODE_ADD_AT    = 2'd1,
    MODE_TICK      = 2'd2,
    MODE_FLUSH     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_EXPIRED  = 3'd2,
    ST_NONE_DUE = 3'd3,
    ST_FLUSHED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [TimeBits-1:0] time_value;
    logic [TagBits-1:0]  event_tag;
    logic [TimeBits-1:0] current_time;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [TagBits-1:0]  out_tag;
    logic [TimeBits-1:0] due_time;
    logic                last;
  } out_beat_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_e                 op;
    logic [TimeBits-1:0] when;
    logic [TagBits-1:0]  tag;
  } cmd_t;

endpackage

FILE: hdl/teq_front.sv
// ----------------------------------------------------------------------------
// teq_front: input decode
// Accepts input beats, resolves the due time of adds and queues commands.
// ----------------------------------------------------------------------------
module teq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  teq_pkg::in_beat_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output teq_pkg::cmd_t    cmd_o
);
  import teq_pkg::*;

  localparam int unsigned PtrBits = $clog2(CmdDepth);

  cmd_t                 fifo_q [CmdDepth];
  logic [PtrBits-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrBits:0]     cnt_q, cnt_d;
  cmd_t                 cmd_new;
  logic [TimeBits:0]    sum;
  logic                 push;

  always_comb begin
    sum = {1'b0, in_data_i.current_time} + {1'b0, in_data_i.time_value};
    cmd_new.tag  = in_data_i.event_tag;
    cmd_new.when = in_data_i.time_value;
    cmd_new.op   = OP_ADD;
    unique case (mode_e'(in_data_i.mode))
      MODE_ADD_AFTER: begin
        // saturate at the top of the time range
        cmd_new.when = sum[TimeBits] ? '1 : sum[TimeBits-1:0];
      end
      MODE_ADD_AT: cmd_new.op = OP_ADD;
      MODE_TICK: begin
        cmd_new.op   = OP_TICK;
        cmd_new.when = in_data_i.current_time;
      end
      MODE_FLUSH: cmd_new.op = OP_FLUSH;
      default: cmd_new.op = OP_FLUSH;
    endcase
  end

  assign in_stall_o  = (cnt_q == (PtrBits+1)'(CmdDepth)) ? 1'b1 : 1'b0;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = cmd_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_new;
    end
  end

endmodule

FILE: hdl/teq_back.sv
// ----------------------------------------------------------------------------
// teq_back: ordered store and result generator
// Shift-register store, earliest first; one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module teq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  teq_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output teq_pkg::out_beat_t out_data_o
);
  import teq_pkg::*;

  logic [TimeBits-1:0] due_q [Capacity];
  logic [TagBits-1:0]  tag_q [Capacity];
  logic [CntBits-1:0]  cnt_q;
  logic                out_valid_q;
  out_beat_t           out_q;
  out_beat_t           out_d;

  logic                slot_free;
  logic                head_due;
  logic                more_due;
  logic                full;
  logic [Capacity-1:0] ge;           // entry i due later than new time

  assign slot_free = !out_valid_q || !out_stall_i;
  assign full      = (cnt_q == CntBits'(Capacity));
  assign head_due  = (cnt_q != '0) && (due_q[0] <= cmd_i.when);
  assign more_due  = (cnt_q > CntBits'(1)) && (due_q[1] <= cmd_i.when);
  assign cmd_pop_o = cmd_valid_i && slot_free &&
                     (cmd_i.op != OP_TICK || !head_due || !more_due);

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      ge[i] = (CntBits'(i) < cnt_q) && (due_q[i] > cmd_i.when);
    end
  end

  always_comb begin
    out_d      = '0;
    out_d.last = 1'b1;
    unique case (cmd_i.op)
      OP_ADD: begin
        out_d.due_time = cmd_i.when;
        out_d.status   = full ? ST_FULL : ST_ACCEPTED;
      end
      OP_TICK: begin
        if (head_due) begin
          out_d.status   = ST_EXPIRED;
          out_d.out_tag  = tag_q[0];
          out_d.due_time = due_q[0];
          out_d.last     = !more_due;
        end else begin
          out_d.status = ST_NONE_DUE;
        end
      end
      OP_FLUSH: out_d.status = ST_FLUSHED;
      default:  out_d.status = ST_FLUSHED;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!slot_free) begin
        // hold
      end else if (!cmd_valid_i) begin
        out_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b1;
        unique case (cmd_i.op)
          OP_ADD:   if (!full) cnt_q <= cnt_q + 1'b1;
          OP_TICK:  if (head_due) cnt_q <= cnt_q - 1'b1;
          OP_FLUSH: cnt_q <= '0;
          default:  cnt_q <= cnt_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && cmd_valid_i) begin
      out_q <= out_d;
      unique case (cmd_i.op)
        OP_ADD: begin
          if (!full) begin
            // shift later entries up, insert after equal times
            for (int i = Capacity - 1; i > 0; i--) begin
              if (ge[i-1]) begin
                due_q[i] <= due_q[i-1];
                tag_q[i] <= tag_q[i-1];
              end else if (ge[i] || CntBits'(i) == cnt_q) begin
                due_q[i] <= cmd_i.when;
                tag_q[i] <= cmd_i.tag;
              end
            end
            if (ge[0] || cnt_q == '0) begin
              due_q[0] <= cmd_i.when;
              tag_q[0] <= cmd_i.tag;
            end
          end
        end
        OP_TICK: begin
          if (head_due) begin
            // advance the store by one
            for (int i = 0; i < Capacity - 1; i++) begin
              due_q[i] <= due_q[i+1];
              tag_q[i] <= tag_q[i+1];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/timed_event_queue_unit.sv
// ----------------------------------------------------------------------------
// timed_event_queue_unit: timer priority queue top level
// Front decode, two-entry command queue, ordered store back end.
// ----------------------------------------------------------------------------
// Input beats carry a mode, a time value, a tag and the timer reading. Adds
// and flushes give one result beat; a tick gives one beat per expired entry
// (earliest first, last set on the final one) or one none-due beat.
// An accepted input beat is written into the command queue, and the back end
// registers its result in the output register. A tick releases expired
// entries one at a time, limited by the single read/shift port of the store.
// The command queue keeps accepting while a result waits in the output
// register. Reset empties the store and the queue. When out_stall_i is high
// the output beat holds and the back end waits; the front end fills its
// queue and then raises in_stall_o.
// ----------------------------------------------------------------------------
module timed_event_queue_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  teq_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output teq_pkg::out_beat_t out_data_o
);
  import teq_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  teq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  teq_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop of empty command queue");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.status == ST_EXPIRED)
    else $error("non-final beat with non-expired status");

endmodule
